// ===== rtl/core/dsf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the damped spring force block: widths, reset values, register
// indexes and the request and stage payload types. Depends on nothing.
package dsf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int D_W       = IN_W + 1;
  localparam int SQ_W      = 2 * D_W;
  localparam int LEN_W     = SQ_W / 2;
  localparam int REM_W     = LEN_W + 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int U_W       = Q_W + 1;
  localparam int NUM_W     = D_W + Q_W + 1;
  localparam int P_W       = U_W + D_W;
  localparam int DOT_W     = P_W + 2;
  localparam int CDOT_W    = DOT_W - FRAC_BITS;
  localparam int KS_W      = 31;
  localparam int KD_W      = 17;
  localparam int R0_W      = 31;
  localparam int ST_W      = LEN_W + 1;
  localparam int KSST_W    = KS_W + 1 + ST_W;
  localparam int KDCD_W    = KD_W + 1 + CDOT_W;
  localparam int SUM_W     = KSST_W + 1;
  localparam int FM_W      = SUM_W - FRAC_BITS;
  localparam int SPLIT     = 26;
  localparam int PLO_W     = SPLIT + 1 + U_W;
  localparam int PHI_W     = FM_W - SPLIT + U_W;
  localparam int T_W       = PHI_W + SPLIT + 1;
  localparam int R_W       = T_W - FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  localparam int CFG_W   = 31;
  localparam int CFG_A_W = 2;

  localparam logic [KS_W-1:0] KS_RESET = KS_W'(65536);
  localparam logic [KD_W-1:0] KD_RESET = KD_W'(65536);
  localparam logic [R0_W-1:0] R0_RESET = R0_W'(65536);

  localparam logic [IN_W-1:0] F_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic [IN_W-1:0] F_MIN = {1'b1, {(IN_W-1){1'b0}}};

  typedef enum logic [CFG_A_W-1:0] {
    REG_SPRING = 2'd0,
    REG_DAMP   = 2'd1,
    REG_REST   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [IN_W-1:0] pos_a_x;
    logic signed [IN_W-1:0] pos_a_y;
    logic signed [IN_W-1:0] pos_a_z;
    logic signed [IN_W-1:0] pos_b_x;
    logic signed [IN_W-1:0] pos_b_y;
    logic signed [IN_W-1:0] pos_b_z;
    logic signed [IN_W-1:0] vel_a_x;
    logic signed [IN_W-1:0] vel_a_y;
    logic signed [IN_W-1:0] vel_a_z;
    logic signed [IN_W-1:0] vel_b_x;
    logic signed [IN_W-1:0] vel_b_y;
    logic signed [IN_W-1:0] vel_b_z;
  } in_req_t;

  typedef struct packed {
    logic signed [IN_W-1:0] force_x;
    logic signed [IN_W-1:0] force_y;
    logic signed [IN_W-1:0] force_z;
    logic                   zero_separation;
    logic                   clipped;
  } out_req_t;

  typedef struct packed {
    logic [KS_W-1:0] spring_gain;
    logic [KD_W-1:0] damping_gain;
    logic [R0_W-1:0] rest_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] dv;
    logic [2:0][D_W-1:0] dmag;
    logic [2:0]          dneg;
    logic                zero;
  } carry_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] dv;
    logic [2:0]          dneg;
    logic [LEN_W-1:0]    len;
    logic                zero;
  } div_pay_t;

endpackage

// ===== rtl/core/dsf_intf.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result streams.
// Depends on dsf_pkg for the payload types.
interface dsf_in_if;
  logic             valid;
  logic             ready;
  dsf_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsf_out_if;
  logic              valid;
  logic              ready;
  dsf_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/damped_spring_force_top.sv =====
`timescale 1ns / 1ps
// Damped spring force between two particles, signed Q16.16 fixed point.
// Top level: configuration registers, pipeline enable and the four stages.
// Depends on dsf_pkg, dsf_intf, dsf_front, dsf_sqrt, dsf_div and dsf_force.
//
// Usage:
//   in_chan carries one request per accepted transfer: positions and
//   velocities of both particles. out_chan returns one result per request,
//   in order: the force on the first particle, a zero separation flag and
//   a saturation flag. The second particle's force is the negation.
//   cfg_we/cfg_addr/cfg_wdata write the spring gain, damping gain and rest
//   length; the user must make writes only while no request is in flight, as the block does not enforce it.
// Stages and throughput:
//   A request passes through 3 front stages, 33 square root stages (one
//   root bit each), 18 divider stages (a preparing stage, then one quotient
//   bit each) and 7 force stages. One request is accepted in every cycle
//   in which the receiver does not hold a result.
// Reset and stall:
//   Reset empties the pipeline and loads gains and rest length of 1.0.
//   When the receiver holds a result, the whole pipeline holds with it and
//   in_chan.ready drops; nothing is lost or repeated.
module damped_spring_force_top (
  input  logic                             clk,
  input  logic                             rst_n,
  dsf_in_if.sink                           in_chan,
  dsf_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [dsf_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [dsf_pkg::CFG_W-1:0]        cfg_wdata
);

  dsf_pkg::cfg_t cfg_r;
  logic en;

  logic                              fr_valid, sq_valid, dv_valid, fo_valid;
  dsf_pkg::carry_t                   fr_carry, sq_carry;
  logic [dsf_pkg::SQ_W-1:0]          fr_sum;
  logic [dsf_pkg::LEN_W-1:0]         sq_len;
  dsf_pkg::div_pay_t                 dv_pay;
  logic [2:0][dsf_pkg::Q_W-1:0]      dv_q;
  dsf_pkg::out_req_t                 fo_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spring_gain  <= dsf_pkg::KS_RESET;
      cfg_r.damping_gain <= dsf_pkg::KD_RESET;
      cfg_r.rest_length  <= dsf_pkg::R0_RESET;
    end else if (cfg_we) begin
      unique case (dsf_pkg::reg_idx_t'(cfg_addr))
        dsf_pkg::REG_SPRING: cfg_r.spring_gain  <= cfg_wdata[dsf_pkg::KS_W-1:0];
        dsf_pkg::REG_DAMP:   cfg_r.damping_gain <= cfg_wdata[dsf_pkg::KD_W-1:0];
        dsf_pkg::REG_REST:   cfg_r.rest_length  <= cfg_wdata[dsf_pkg::R0_W-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !fo_valid || out_chan.ready;
  assign in_chan.ready = en;

  dsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .in_data   (in_chan.data),
    .out_valid (fr_valid),
    .out_carry (fr_carry),
    .out_sum   (fr_sum)
  );

  dsf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_carry  (fr_carry),
    .in_sum    (fr_sum),
    .out_valid (sq_valid),
    .out_carry (sq_carry),
    .out_len   (sq_len)
  );

  dsf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_carry  (sq_carry),
    .in_len    (sq_len),
    .out_valid (dv_valid),
    .out_pay   (dv_pay),
    .out_q     (dv_q)
  );

  dsf_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (dv_valid),
    .in_pay    (dv_pay),
    .in_q      (dv_q),
    .out_valid (fo_valid),
    .out_data  (fo_data)
  );

  assign out_chan.valid = fo_valid;
  assign out_chan.data  = fo_data;

endmodule

// ===== rtl/core/dsf_front.sv =====
`timescale 1ns / 1ps
// Front stages: separation and velocity difference, squares, sum of squares.
// Depends on dsf_pkg.
module dsf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  dsf_pkg::in_req_t           in_data,
  output logic                       out_valid,
  output dsf_pkg::carry_t            out_carry,
  output logic [dsf_pkg::SQ_W-1:0]   out_sum
);

  logic [2:0][dsf_pkg::IN_W-1:0] pa, pb, va, vb;
  logic signed [dsf_pkg::D_W-1:0] d_w [3];
  dsf_pkg::carry_t c0_nxt, c0_r, c1_r, c2_r;
  logic v0_r, v1_r, v2_r;
  logic [dsf_pkg::SQ_W-1:0] sq1_r [3];
  logic [dsf_pkg::SQ_W-1:0] sum2_r;

  assign pa = {in_data.pos_a_z, in_data.pos_a_y, in_data.pos_a_x};
  assign pb = {in_data.pos_b_z, in_data.pos_b_y, in_data.pos_b_x};
  assign va = {in_data.vel_a_z, in_data.vel_a_y, in_data.vel_a_x};
  assign vb = {in_data.vel_b_z, in_data.vel_b_y, in_data.vel_b_x};

  always_comb begin
    c0_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      d_w[i] = $signed({pa[i][dsf_pkg::IN_W-1], pa[i]})
             - $signed({pb[i][dsf_pkg::IN_W-1], pb[i]});
      c0_nxt.dv[i] = $signed({va[i][dsf_pkg::IN_W-1], va[i]})
                   - $signed({vb[i][dsf_pkg::IN_W-1], vb[i]});
      c0_nxt.dneg[i] = d_w[i][dsf_pkg::D_W-1];
      c0_nxt.dmag[i] = d_w[i][dsf_pkg::D_W-1] ? dsf_pkg::D_W'(-d_w[i]) : d_w[i];
    end
    c0_nxt.zero = (d_w[0] == '0) && (d_w[1] == '0) && (d_w[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= c0_nxt;
      c1_r <= c0_r;
      c2_r <= c1_r;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= dsf_pkg::SQ_W'(c0_r.dmag[i]) * dsf_pkg::SQ_W'(c0_r.dmag[i]);
      end
      sum2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  assign out_valid = v2_r;
  assign out_carry = c2_r;
  assign out_sum   = sum2_r;

endmodule

// ===== rtl/core/dsf_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on dsf_pkg.
module dsf_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  dsf_pkg::carry_t            in_carry,
  input  logic [dsf_pkg::SQ_W-1:0]   in_sum,
  output logic                       out_valid,
  output dsf_pkg::carry_t            out_carry,
  output logic [dsf_pkg::LEN_W-1:0]  out_len
);

  localparam int STEPS = dsf_pkg::LEN_W;

  logic                        v_r    [1:STEPS];
  logic [dsf_pkg::REM_W-1:0]   rem_r  [1:STEPS];
  logic [dsf_pkg::LEN_W-1:0]   root_r [1:STEPS];
  logic [dsf_pkg::SQ_W-1:0]    rad_r  [1:STEPS];
  dsf_pkg::carry_t             c_r    [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic                        vin;
    logic [dsf_pkg::REM_W-1:0]   rem_in;
    logic [dsf_pkg::LEN_W-1:0]   root_in;
    logic [dsf_pkg::SQ_W-1:0]    rad_in;
    dsf_pkg::carry_t             c_in;
    logic [dsf_pkg::REM_W+1:0]   cand;
    logic [dsf_pkg::REM_W+1:0]   trial;
    logic                        take;

    if (j == 0) begin : g_first
      assign vin     = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_sum;
      assign c_in    = in_carry;
    end else begin : g_next
      assign vin     = v_r[j];
      assign rem_in  = rem_r[j];
      assign root_in = root_r[j];
      assign rad_in  = rad_r[j];
      assign c_in    = c_r[j];
    end

    assign cand  = {rem_in, rad_in[dsf_pkg::SQ_W-1-2*j -: 2]};
    assign trial = (dsf_pkg::REM_W+2)'({root_in, 2'b01});
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= take ? dsf_pkg::REM_W'(cand - trial) : dsf_pkg::REM_W'(cand);
        root_r[j+1] <= {root_in[dsf_pkg::LEN_W-2:0], take};
        rad_r[j+1]  <= rad_in;
        c_r[j+1]    <= c_in;
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_carry = c_r[STEPS];
  assign out_len   = root_r[STEPS];

endmodule

// ===== rtl/core/dsf_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider forming the three rounded direction magnitudes
// |d| * 2^FRAC_BITS / len, one quotient bit per stage after a preparing stage. Depends on dsf_pkg.
module dsf_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  dsf_pkg::carry_t                      in_carry,
  input  logic [dsf_pkg::LEN_W-1:0]            in_len,
  output logic                                 out_valid,
  output dsf_pkg::div_pay_t                    out_pay,
  output logic [2:0][dsf_pkg::Q_W-1:0]         out_q
);

  localparam int STEPS = dsf_pkg::Q_W;

  logic                                vp_r;
  logic [2:0][dsf_pkg::NUM_W-1:0]      nump_r;
  dsf_pkg::div_pay_t                   payp_r;
  dsf_pkg::div_pay_t                   pay_nxt;

  logic                                v_r   [1:STEPS];
  logic [2:0][dsf_pkg::NUM_W-1:0]      rem_r [1:STEPS];
  logic [2:0][dsf_pkg::Q_W-1:0]        q_r   [1:STEPS];
  dsf_pkg::div_pay_t                   pay_r [1:STEPS];

  always_comb begin
    pay_nxt.dv   = in_carry.dv;
    pay_nxt.dneg = in_carry.dneg;
    pay_nxt.len  = in_len;
    pay_nxt.zero = in_carry.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      payp_r <= pay_nxt;
      for (int i = 0; i < 3; i++) begin
        nump_r[i] <= dsf_pkg::NUM_W'({in_carry.dmag[i], {(dsf_pkg::Q_W){1'b0}}})
                   + dsf_pkg::NUM_W'(in_len);
      end
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int SH = STEPS - 1 - j;
    logic                              vin;
    logic [2:0][dsf_pkg::NUM_W-1:0]    rem_in, rem_nxt;
    logic [2:0][dsf_pkg::Q_W-1:0]      q_in, q_nxt;
    dsf_pkg::div_pay_t                 pay_in;
    logic [dsf_pkg::NUM_W-1:0]         trial;

    if (j == 0) begin : g_first
      assign vin    = vp_r;
      assign rem_in = nump_r;
      assign q_in   = '0;
      assign pay_in = payp_r;
    end else begin : g_next
      assign vin    = v_r[j];
      assign rem_in = rem_r[j];
      assign q_in   = q_r[j];
      assign pay_in = pay_r[j];
    end

    assign trial = dsf_pkg::NUM_W'({pay_in.len, 1'b0}) << SH;

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= trial) begin
          rem_nxt[i]   = rem_in[i] - trial;
          q_nxt[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= rem_nxt;
        q_r[j+1]   <= q_nxt;
        pay_r[j+1] <= pay_in;
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_pay   = pay_r[STEPS];
  assign out_q     = q_r[STEPS];

endmodule

// ===== rtl/core/dsf_force.sv =====
`timescale 1ns / 1ps
// Force stages: signed direction, closing rate, spring and damping terms,
// force scaling, rounding and saturation into the output register.
// Depends on dsf_pkg.
module dsf_force (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  dsf_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  input  dsf_pkg::div_pay_t              in_pay,
  input  logic [2:0][dsf_pkg::Q_W-1:0]   in_q,
  output logic                           out_valid,
  output dsf_pkg::out_req_t              out_data
);

  localparam int R_HI = dsf_pkg::IN_W - 1;

  logic [6:0] v_r;
  logic [6:0] z_r;

  logic signed [dsf_pkg::U_W-1:0]    u0_r [3], u1_r [3], u2_r [3], u3_r [3], u4_r [3];
  logic signed [dsf_pkg::D_W-1:0]    dv0_r [3];
  logic [dsf_pkg::LEN_W-1:0]         len0_r;

  logic signed [dsf_pkg::P_W-1:0]    p1_r [3];
  logic signed [dsf_pkg::ST_W-1:0]   st1_r;

  logic signed [dsf_pkg::DOT_W-1:0]  dot2;
  logic signed [dsf_pkg::CDOT_W-1:0] cdot2_r;
  logic signed [dsf_pkg::KSST_W-1:0] ksst2_r, ksst3_r;

  logic signed [dsf_pkg::KDCD_W-1:0] kdcd3_r;

  logic signed [dsf_pkg::SUM_W-1:0]  sum4;
  logic signed [dsf_pkg::FM_W-1:0]   fm4_r;

  logic signed [dsf_pkg::PLO_W-1:0]  plo5_r [3];
  logic signed [dsf_pkg::PHI_W-1:0]  phi5_r [3];

  logic signed [dsf_pkg::T_W-1:0]    t6 [3];
  logic [dsf_pkg::R_W-1:0]           r6 [3];
  logic [dsf_pkg::IN_W-1:0]          f6 [3];
  logic [2:0]                        clip6;
  dsf_pkg::out_req_t                 out_nxt, out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_comb begin
    dot2 = dsf_pkg::DOT_W'(p1_r[0]) + dsf_pkg::DOT_W'(p1_r[1]) + dsf_pkg::DOT_W'(p1_r[2])
         + dsf_pkg::DOT_W'(dsf_pkg::HALF);
    sum4 = dsf_pkg::SUM_W'(ksst3_r) + dsf_pkg::SUM_W'(kdcd3_r)
         + dsf_pkg::SUM_W'(dsf_pkg::HALF);
    for (int i = 0; i < 3; i++) begin
      t6[i] = dsf_pkg::T_W'(dsf_pkg::HALF)
            - (dsf_pkg::T_W'(phi5_r[i]) <<< dsf_pkg::SPLIT)
            - dsf_pkg::T_W'(plo5_r[i]);
      r6[i] = t6[i][dsf_pkg::T_W-1:dsf_pkg::FRAC_BITS];
      clip6[i] = 1'b0;
      f6[i] = r6[i][dsf_pkg::IN_W-1:0];
      if (!r6[i][dsf_pkg::R_W-1] && (|r6[i][dsf_pkg::R_W-1:R_HI])) begin
        f6[i] = dsf_pkg::F_MAX;
        clip6[i] = 1'b1;
      end else if (r6[i][dsf_pkg::R_W-1] && !(&r6[i][dsf_pkg::R_W-1:R_HI])) begin
        f6[i] = dsf_pkg::F_MIN;
        clip6[i] = 1'b1;
      end
    end
    if (z_r[5]) begin
      out_nxt = '0;
      out_nxt.zero_separation = 1'b1;
    end else begin
      out_nxt.force_x = f6[0];
      out_nxt.force_y = f6[1];
      out_nxt.force_z = f6[2];
      out_nxt.zero_separation = 1'b0;
      out_nxt.clipped = |clip6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r    <= {z_r[5:0], in_pay.zero};
      len0_r <= in_pay.len;
      st1_r  <= $signed({1'b0, len0_r}) - $signed({3'b000, cfg.rest_length});
      cdot2_r <= dot2[dsf_pkg::DOT_W-1:dsf_pkg::FRAC_BITS];
      ksst2_r <= $signed({1'b0, cfg.spring_gain}) * st1_r;
      ksst3_r <= ksst2_r;
      kdcd3_r <= $signed({1'b0, cfg.damping_gain}) * cdot2_r;
      fm4_r   <= sum4[dsf_pkg::SUM_W-1:dsf_pkg::FRAC_BITS];
      out_r   <= out_nxt;
      for (int i = 0; i < 3; i++) begin
        u0_r[i]  <= in_pay.dneg[i] ? dsf_pkg::U_W'(-{1'b0, in_q[i]})
                                   : dsf_pkg::U_W'({1'b0, in_q[i]});
        dv0_r[i] <= in_pay.dv[i];
        u1_r[i]  <= u0_r[i];
        u2_r[i]  <= u1_r[i];
        u3_r[i]  <= u2_r[i];
        u4_r[i]  <= u3_r[i];
        p1_r[i]  <= u0_r[i] * dv0_r[i];
        plo5_r[i] <= $signed({1'b0, fm4_r[dsf_pkg::SPLIT-1:0]}) * u4_r[i];
        phi5_r[i] <= $signed(fm4_r[dsf_pkg::FM_W-1:dsf_pkg::SPLIT]) * u4_r[i];
      end
    end
  end

  assign out_valid = v_r[6];
  assign out_data  = out_r;

endmodule

// ===== rtl/core/dsf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the damped spring force block, bound to the top.
// Depends on dsf_pkg and damped_spring_force_top.
module dsf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dsf_pkg::out_req_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with an empty output");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("request held off without a stalled result");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_separation |->
      out_data.force_x == '0 && out_data.force_y == '0 &&
      out_data.force_z == '0 && !out_data.clipped)
    else $error("zero separation with non-zero force");

  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |->
      out_data.force_x == dsf_pkg::F_MAX || out_data.force_x == dsf_pkg::F_MIN ||
      out_data.force_y == dsf_pkg::F_MAX || out_data.force_y == dsf_pkg::F_MIN ||
      out_data.force_z == dsf_pkg::F_MAX || out_data.force_z == dsf_pkg::F_MIN)
    else $error("clipped flag without a saturated component");

endmodule

bind damped_spring_force_top dsf_checker u_dsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// ===== bench/tb_damped_spring_force_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for damped_spring_force_top: drives random and corner
// requests, predicts each force in wide integer arithmetic and compares.
// Depends on dsf_pkg, dsf_intf and the block's RTL.
module tb_damped_spring_force_top;

  typedef logic signed [127:0] wide_t;

  localparam logic [dsf_pkg::CFG_A_W-1:0] REG_UNUSED = 2'd3;
  localparam int LATENCY = 60;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dsf_pkg::CFG_A_W-1:0] cfg_addr = '0;
  logic [dsf_pkg::CFG_W-1:0] cfg_wdata = '0;

  dsf_in_if in_chan ();
  dsf_out_if out_chan ();

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
  end

  damped_spring_force_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [dsf_pkg::KS_W-1:0] model_ks = dsf_pkg::KS_RESET;
  logic [dsf_pkg::KD_W-1:0] model_kd = dsf_pkg::KD_RESET;
  logic [dsf_pkg::R0_W-1:0] model_r0 = dsf_pkg::R0_RESET;

  dsf_pkg::in_req_t  request_queue[$];
  dsf_pkg::out_req_t force_expected[$];
  int       errors = 0;
  int       requests_sent = 0;
  int       results_checked = 0;
  int       zero_seen = 0;
  int       clip_seen = 0;
  bit       no_gaps = 1'b0;
  bit       long_hold_req = 1'b0;
  bit       sender_hold = 1'b0;
  int       send_gap = 0;
  int       recv_stall = 0;
  int       hold_cnt = 0;
  int       quiet_cycles = 0;

  function automatic dsf_pkg::out_req_t predict_force(dsf_pkg::in_req_t r);
    wide_t pa[3], pb[3], va[3], vb[3], d[3], dv[3], u[3], fo[3];
    wide_t m, sumsq, len, c, dot, cdot, stretch, fm, f, t, half;
    dsf_pkg::out_req_t res;
    res = '0;
    half = wide_t'(dsf_pkg::HALF);
    pa[0] = r.pos_a_x; pa[1] = r.pos_a_y; pa[2] = r.pos_a_z;
    pb[0] = r.pos_b_x; pb[1] = r.pos_b_y; pb[2] = r.pos_b_z;
    va[0] = r.vel_a_x; va[1] = r.vel_a_y; va[2] = r.vel_a_z;
    vb[0] = r.vel_b_x; vb[1] = r.vel_b_y; vb[2] = r.vel_b_z;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = pa[i] - pb[i];
      dv[i] = va[i] - vb[i];
      sumsq = sumsq + d[i] * d[i];
    end
    if (sumsq == 0) begin
      res.zero_separation = 1'b1;
      return res;
    end
    len = 0;
    for (int b = 33; b >= 0; b--) begin
      c = len | (wide_t'(1) <<< b);
      if (c * c <= sumsq) len = c;
    end
    for (int i = 0; i < 3; i++) begin
      m = (d[i] < 0) ? -d[i] : d[i];
      u[i] = ((m <<< (dsf_pkg::FRAC_BITS + 1)) + len) / (len <<< 1);
      if (d[i] < 0) u[i] = -u[i];
    end
    dot = u[0] * dv[0] + u[1] * dv[1] + u[2] * dv[2];
    cdot = (dot + half) >>> dsf_pkg::FRAC_BITS;
    stretch = len - wide_t'(model_r0);
    fm = (wide_t'(model_ks) * stretch + wide_t'(model_kd) * cdot + half)
         >>> dsf_pkg::FRAC_BITS;
    f = -fm;
    for (int i = 0; i < 3; i++) begin
      t = (f * u[i] + half) >>> dsf_pkg::FRAC_BITS;
      if (t > wide_t'(32'sh7fffffff)) begin
        t = wide_t'(32'sh7fffffff);
        res.clipped = 1'b1;
      end else if (t < -wide_t'(64'sh80000000)) begin
        t = -wide_t'(64'sh80000000);
        res.clipped = 1'b1;
      end
      fo[i] = t;
    end
    res.force_x = fo[0][31:0];
    res.force_y = fo[1][31:0];
    res.force_z = fo[2][31:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
    endcase
  endfunction

  function automatic dsf_pkg::in_req_t random_request();
    dsf_pkg::in_req_t r;
    int pm, vm;
    pm = $urandom_range(0, 3);
    vm = $urandom_range(0, 2);
    r.pos_a_x = rand_coord(pm); r.pos_a_y = rand_coord(pm); r.pos_a_z = rand_coord(pm);
    if (pm == 0 || $urandom_range(0, 3) == 0) begin
      r.pos_b_x = rand_coord(pm); r.pos_b_y = rand_coord(pm); r.pos_b_z = rand_coord(pm);
    end else begin
      r.pos_b_x = r.pos_a_x + rand_coord(pm);
      r.pos_b_y = r.pos_a_y + rand_coord(pm);
      r.pos_b_z = r.pos_a_z + rand_coord(pm);
    end
    if ($urandom_range(0, 19) == 0) begin
      r.pos_b_x = r.pos_a_x; r.pos_b_y = r.pos_a_y; r.pos_b_z = r.pos_a_z;
    end
    r.vel_a_x = rand_coord(vm); r.vel_a_y = rand_coord(vm); r.vel_a_z = rand_coord(vm);
    r.vel_b_x = rand_coord(vm); r.vel_b_y = rand_coord(vm); r.vel_b_z = rand_coord(vm);
    return r;
  endfunction

  function automatic dsf_pkg::in_req_t make_request(
      logic [31:0] ax, ay, az, bx, by, bz,
      logic [31:0] vax, vay, vaz, vbx, vby, vbz);
    dsf_pkg::in_req_t r;
    r.pos_a_x = ax; r.pos_a_y = ay; r.pos_a_z = az;
    r.pos_b_x = bx; r.pos_b_y = by; r.pos_b_z = bz;
    r.vel_a_x = vax; r.vel_a_y = vay; r.vel_a_z = vaz;
    r.vel_b_x = vbx; r.vel_b_y = vby; r.vel_b_z = vbz;
    return r;
  endfunction

  // Request driver: one gap drawn per request, never lowering and raising
  // valid in the same step.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        force_expected.push_back(predict_force(in_chan.data));
        requests_sent++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (request_queue.size() > 0 && !sender_hold) begin
          in_chan.data <= request_queue.pop_front();
          in_chan.valid <= 1'b1;
          send_gap = no_gaps ? 0 : $urandom_range(0, 19);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall control.
  always @(posedge clk) begin
    dsf_pkg::out_req_t exp_res, got;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        results_checked++;
        if (got.zero_separation) zero_seen++;
        if (got.clipped) clip_seen++;
        if (force_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result %h", got);
        end else begin
          exp_res = force_expected.pop_front();
          if (got !== exp_res) begin
            errors++;
            if (errors <= 10)
              $display({"ERROR: result %0d expected f=(%h %h %h) z=%b c=%b",
                        " got f=(%h %h %h) z=%b c=%b"},
                       results_checked, exp_res.force_x, exp_res.force_y, exp_res.force_z,
                       exp_res.zero_separation, exp_res.clipped, got.force_x, got.force_y,
                       got.force_z, got.zero_separation, got.clipped);
          end
        end
        recv_stall = no_gaps ? 0 : $urandom_range(0, 19);
      end
      if (long_hold_req && hold_cnt == 0) begin
        long_hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_chan.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [dsf_pkg::CFG_A_W-1:0] idx,
                           logic [dsf_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      dsf_pkg::REG_SPRING: model_ks = value[dsf_pkg::KS_W-1:0];
      dsf_pkg::REG_DAMP:   model_kd = value[dsf_pkg::KD_W-1:0];
      dsf_pkg::REG_REST:   model_r0 = value[dsf_pkg::R0_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (request_queue.size() > 0 || in_chan.valid || force_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) request_queue.push_back(random_request());
  endtask

  initial begin
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first, with the corner requests, then maximum spring gain and zero rest length.
    request_queue.push_back(make_request(0, 0, 0, 0, 0, 0, mx, mn, mx, mn, mx, mn));
    request_queue.push_back(make_request(mx, mx, mx, mn, mn, mn, mx, mx, mx, mn, mn, mn));
    request_queue.push_back(make_request(mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx));
    request_queue.push_back(make_request(mx, 0, 0, mn, 0, 0, 0, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(0, mx, 0, 0, mn, 0, 0, mx, 0, 0, mn, 0));
    request_queue.push_back(make_request(0, 0, mn, 0, 0, mx, 0, 0, mn, 0, 0, mx));
    request_queue.push_back(make_request(32'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(1, 0, 0, 0, 0, 0, mx, 0, 0, mn, 0, 0));
    request_queue.push_back(make_request(0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(mx, mx, mx, mx, mx, mx, 5, 6, 7, 8, 9, 10));
    request_queue.push_back(make_request(32'h30000, 32'h40000, 0, 0, 0, 0,
                                         32'h10000, 0, 0, 0, 32'h10000, 0));
    request_queue.push_back(make_request(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                         0, 0, 0, mx, mx, mx, 0, 0, 0));
    wait_idle();
    write_reg(dsf_pkg::REG_SPRING, dsf_pkg::KS_W'(32'h7fffffff));
    write_reg(dsf_pkg::REG_DAMP, 31'd65536);
    write_reg(dsf_pkg::REG_REST, 31'd0);
    request_queue.push_back(make_request(mx, mx, mx, mn, mn, mn, 0, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(32'h20000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    request_queue.push_back(make_request(5, 5, 5, 5, 5, 5, mx, mx, mx, mn, mn, mn));
    run_random(180);
    wait_idle();

    // Zero gains, with a pause of the sender half way.
    write_reg(dsf_pkg::REG_SPRING, 31'd0);
    write_reg(dsf_pkg::REG_DAMP, 31'd0);
    write_reg(dsf_pkg::REG_REST, 31'h7fffffff);
    run_random(90);
    while (request_queue.size() > 0 || in_chan.valid) @(posedge clk);
    sender_hold = 1'b1;
    while (force_expected.size() > 0) @(posedge clk);
    sender_hold = 1'b0;
    run_random(90);
    wait_idle();

    // Damping above 1.0, back to back with a long receiver hold-off.
    write_reg(dsf_pkg::REG_DAMP, 31'd131071);
    write_reg(dsf_pkg::REG_SPRING, 31'd65536);
    write_reg(dsf_pkg::REG_REST, 31'd65536);
    write_reg(REG_UNUSED, 31'h5a5a5a5);
    no_gaps = 1'b1;
    run_random(200);
    repeat (20) @(posedge clk);
    long_hold_req = 1'b1;
    wait_idle();
    no_gaps = 1'b0;

    for (int p = 0; p < 4; p++) begin
      write_reg(dsf_pkg::REG_SPRING, 31'($urandom()));
      write_reg(dsf_pkg::REG_DAMP,
                (p == 3) ? 31'($urandom()) : 31'($urandom_range(0, 65536)));
      write_reg(dsf_pkg::REG_REST,
                (p == 1) ? 31'($urandom_range(0, 1 << 20)) : 31'($urandom()));
      no_gaps = (p == 2);
      run_random(150);
      wait_idle();
    end
    no_gaps = 1'b0;

    if (force_expected.size() != 0) begin
      errors++;
      $display("ERROR: %0d results never arrived", force_expected.size());
    end
    $display("Covered %0d requests over eight gain settings, %0d coincident, %0d saturated.",
             requests_sent, zero_seen, clip_seen);
    $display("Mismatches counted: %0d", errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
